// File: design/x86dec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86dec_pkg
// Shared types, codes and opcode decode functions for the 16-bit x86
// instruction decoder.
// ----------------------------------------------------------------------------
package x86dec_pkg;

  localparam int OffsetBitsDefault = 16;

  // operation codes
  localparam logic [2:0] OP_MOV  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_CMP  = 3'd3;
  localparam logic [2:0] OP_JUMP = 3'd4;

  // form codes
  localparam logic [2:0] FORM_RM_REG     = 3'd0;
  localparam logic [2:0] FORM_IMM_REG    = 3'd1;
  localparam logic [2:0] FORM_IMM_RM     = 3'd2;
  localparam logic [2:0] FORM_MEM_TO_ACC = 3'd3;
  localparam logic [2:0] FORM_ACC_TO_MEM = 3'd4;
  localparam logic [2:0] FORM_IMM_ACC    = 3'd5;
  localparam logic [2:0] FORM_RELATIVE   = 3'd6;

  // reg field values of the immediate group
  localparam logic [2:0] GRP_ADD = 3'd0;
  localparam logic [2:0] GRP_SUB = 3'd5;
  localparam logic [2:0] GRP_CMP = 3'd7;

  // opcode top five bits of the alu forms
  localparam logic [4:0] TOP_ADD = 5'd0;
  localparam logic [4:0] TOP_SUB = 5'd5;
  localparam logic [4:0] TOP_CMP = 5'd7;

  localparam logic [1:0] MOD_MEM    = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP16 = 2'd2;
  localparam logic [2:0] RM_DIRECT  = 3'd6;

  localparam logic [3:0] JCC_NIBBLE = 4'h7;

  typedef enum logic [3:0] {
    K_BAD    = 4'd0,
    K_RMREG  = 4'd1,
    K_IMMREG = 4'd2,
    K_IMMRM  = 4'd3,
    K_GROUP  = 4'd4,
    K_MEMACC = 4'd5,
    K_ACCMEM = 4'd6,
    K_IMMACC = 4'd7,
    K_REL    = 4'd8
  } kind_t;

  typedef enum logic [6:0] {
    PH_OPCODE  = 7'b0000001,
    PH_MODRM   = 7'b0000010,
    PH_DISP_LO = 7'b0000100,
    PH_DISP_HI = 7'b0001000,
    PH_IMM_LO  = 7'b0010000,
    PH_IMM_HI  = 7'b0100000,
    PH_REL     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         form;
    logic [4:0]         jump_kind;
    logic               wide;
    logic               to_register;
    logic [7:0]         modrm_value;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [15:0]        jump_target;
    logic [15:0]        start_offset;
    logic [2:0]         length;
    logic               invalid;
  } out_item_t;

  function automatic kind_t classify(input logic [7:0] o);
    kind_t k;
    case (o) inside
      [8'h88:8'h8B], [8'h00:8'h03], [8'h28:8'h2B], [8'h38:8'h3B]: k = K_RMREG;
      [8'hB0:8'hBF]:                                              k = K_IMMREG;
      [8'hC6:8'hC7]:                                              k = K_IMMRM;
      [8'hA0:8'hA1]:                                              k = K_MEMACC;
      [8'hA2:8'hA3]:                                              k = K_ACCMEM;
      [8'h80:8'h83]:                                              k = K_GROUP;
      [8'h04:8'h05], [8'h2C:8'h2D], [8'h3C:8'h3D]:                k = K_IMMACC;
      [8'h70:8'h7F], [8'hE0:8'hE3]:                               k = K_REL;
      default:                                                    k = K_BAD;
    endcase
    return k;
  endfunction

  // displacement bytes: 0, 1 or 2
  function automatic logic [1:0] disp_len(input kind_t k, input logic [7:0] m);
    logic [1:0] n;
    n = 2'd0;
    if (k == K_MEMACC || k == K_ACCMEM) begin
      n = 2'd2;
    end else if (k == K_RMREG || k == K_IMMRM || k == K_GROUP) begin
      if (m[7:6] == MOD_DISP8) begin
        n = 2'd1;
      end else if (m[7:6] == MOD_DISP16) begin
        n = 2'd2;
      end else if (m[7:6] == MOD_MEM && m[2:0] == RM_DIRECT) begin
        n = 2'd2;
      end
    end
    return n;
  endfunction

  // immediate bytes: 0, 1 or 2
  function automatic logic [1:0] imm_len(input kind_t k, input logic [7:0] o);
    logic [1:0] n;
    case (k)
      K_IMMREG:          n = o[3] ? 2'd2 : 2'd1;
      K_IMMRM, K_IMMACC: n = o[0] ? 2'd2 : 2'd1;
      K_GROUP:           n = (o[1:0] == 2'b01) ? 2'd2 : 2'd1;
      default:           n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: design/x86dec_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86dec channel interfaces
// Valid/ready channels for code bytes in and decoded instructions out.
// ----------------------------------------------------------------------------
interface x86dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       program_start;

  modport source (output valid, output code_byte, output program_start, input ready);
  modport sink   (input valid, input code_byte, input program_start, output ready);
endinterface

interface x86dec_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [2:0]         form;
  logic [4:0]         jump_kind;
  logic               wide;
  logic               to_register;
  logic [7:0]         modrm_value;
  logic signed [15:0] displacement;
  logic [15:0]        immediate;
  logic [15:0]        jump_target;
  logic [15:0]        start_offset;
  logic [2:0]         length;
  logic               invalid;

  modport source (
    output valid, output operation, output form, output jump_kind, output wide,
    output to_register, output modrm_value, output displacement, output immediate,
    output jump_target, output start_offset, output length, output invalid,
    input ready
  );
  modport sink (
    input valid, input operation, input form, input jump_kind, input wide,
    input to_register, input modrm_value, input displacement, input immediate,
    input jump_target, input start_offset, input length, input invalid,
    output ready
  );
endinterface
`default_nettype wire

// File: design/x86_16bit_instruction_decoder_unit.sv
// result: a completing code byte writes its result to the result register,
// or to the skid register while the output is stalled; other bytes give none
// throughput: one code byte per cycle while the skid register is empty, set
// by the single decode pass from the state registers into the result register;
// a skid register keeps input open for one more result while one is stalled
// reset: synchronous active-low reset clears the decode state and offset
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder_unit
// Byte-serial decoder for 8086 mov/add/sub/cmp and conditional jump/loop
// instructions, one result transaction per completed instruction.
// ----------------------------------------------------------------------------
module x86_16bit_instruction_decoder_unit #(
  parameter int OFFSET_BITS = x86dec_pkg::OffsetBitsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  x86dec_in_if.sink      in_ch,
  x86dec_out_if.source   out_ch
);
  import x86dec_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             opcode_r, opcode_nxt;
  logic [7:0]             modrm_r, modrm_nxt;
  logic [15:0]            disp_r, disp_nxt;
  logic [15:0]            imm_r, imm_nxt;
  logic [OFFSET_BITS-1:0] cur_off_r, cur_off_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;

  out_item_t              out_item_r, skid_item_r, item;
  logic                   out_valid_r, skid_valid_r;

  phase_t                 phase_cur;
  logic [OFFSET_BITS-1:0] off_base;
  logic [OFFSET_BITS-1:0] len_full;
  kind_t                  kind;
  logic [1:0]             dl, il;
  logic [5:0]             need, above, cand;
  logic                   done;
  logic                   in_fire, out_fire, res_fire;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // decode pass for the byte on the input
  always_comb begin
    phase_cur  = in_ch.program_start ? PH_OPCODE : phase_r;
    off_base   = in_ch.program_start ? '0 : cur_off_r;
    opcode_nxt = opcode_r;
    modrm_nxt  = modrm_r;
    disp_nxt   = disp_r;
    imm_nxt    = imm_r;
    start_nxt  = start_r;
    above      = 6'b000000;

    case (phase_cur)
      PH_OPCODE: begin
        start_nxt  = off_base;
        opcode_nxt = in_ch.code_byte;
        modrm_nxt  = 8'h00;
        disp_nxt   = 16'h0000;
        imm_nxt    = 16'h0000;
        above      = 6'b111111;
      end
      PH_MODRM: begin
        modrm_nxt = in_ch.code_byte;
        above     = 6'b111110;
      end
      PH_DISP_LO: begin
        disp_nxt = {8'h00, in_ch.code_byte};
        above    = 6'b111100;
      end
      PH_DISP_HI: begin
        disp_nxt = {in_ch.code_byte, disp_r[7:0]};
        above    = 6'b111000;
      end
      PH_IMM_LO: begin
        imm_nxt = {8'h00, in_ch.code_byte};
        above   = 6'b110000;
      end
      PH_IMM_HI: begin
        imm_nxt = {in_ch.code_byte, imm_r[7:0]};
        above   = 6'b100000;
      end
      PH_REL: begin
        disp_nxt = {8'h00, in_ch.code_byte};
        above    = 6'b000000;
      end
      default: begin
        above = 6'b000000;
      end
    endcase

    cur_off_nxt = off_base + OFFSET_BITS'(1);
    len_full    = cur_off_nxt - start_nxt;

    kind = classify(opcode_nxt);
    dl   = disp_len(kind, modrm_nxt);
    il   = imm_len(kind, opcode_nxt);
    need = {kind == K_REL, il == 2'd2, il != 2'd0, dl == 2'd2, dl != 2'd0,
            kind == K_RMREG || kind == K_IMMRM || kind == K_GROUP};
    cand = (kind == K_BAD) ? 6'b000000 : (need & above);

    done      = 1'b0;
    phase_nxt = PH_OPCODE;
    if (cand[0]) begin
      phase_nxt = PH_MODRM;
    end else if (cand[1]) begin
      phase_nxt = PH_DISP_LO;
    end else if (cand[2]) begin
      phase_nxt = PH_DISP_HI;
    end else if (cand[3]) begin
      phase_nxt = PH_IMM_LO;
    end else if (cand[4]) begin
      phase_nxt = PH_IMM_HI;
    end else if (cand[5]) begin
      phase_nxt = PH_REL;
    end else begin
      done = 1'b1;
    end
  end

  assign res_fire = in_fire && done;

  x86dec_fields u_fields (
    .opcode       (opcode_nxt),
    .modrm        (modrm_nxt),
    .disp         (disp_nxt),
    .imm          (imm_nxt),
    .next_offset  (cur_off_nxt[15:0]),
    .start_offset (start_nxt[15:0]),
    .length       (len_full[2:0]),
    .item         (item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OPCODE;
      opcode_r  <= 8'h00;
      modrm_r   <= 8'h00;
      disp_r    <= 16'h0000;
      imm_r     <= 16'h0000;
      cur_off_r <= '0;
      start_r   <= '0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      opcode_r  <= opcode_nxt;
      modrm_r   <= modrm_nxt;
      disp_r    <= disp_nxt;
      imm_r     <= imm_nxt;
      cur_off_r <= cur_off_nxt;
      start_r   <= start_nxt;
    end
  end

  // result register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_item_r   <= skid_item_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_r || out_fire) begin
        out_item_r  <= item;
        out_valid_r <= 1'b1;
      end else begin
        skid_item_r  <= item;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.operation    = out_item_r.operation;
  assign out_ch.form         = out_item_r.form;
  assign out_ch.jump_kind    = out_item_r.jump_kind;
  assign out_ch.wide         = out_item_r.wide;
  assign out_ch.to_register  = out_item_r.to_register;
  assign out_ch.modrm_value  = out_item_r.modrm_value;
  assign out_ch.displacement = out_item_r.displacement;
  assign out_ch.immediate    = out_item_r.immediate;
  assign out_ch.jump_target  = out_item_r.jump_target;
  assign out_ch.start_offset = out_item_r.start_offset;
  assign out_ch.length       = out_item_r.length;
  assign out_ch.invalid      = out_item_r.invalid;

endmodule
`default_nettype wire

// File: design/x86dec_fields.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86dec_fields
// Builds the result transaction of a completed instruction from its
// collected opcode, modrm, displacement and immediate bytes.
// ----------------------------------------------------------------------------
module x86dec_fields (
  input  wire logic [7:0]             opcode,
  input  wire logic [7:0]             modrm,
  input  wire logic [15:0]            disp,
  input  wire logic [15:0]            imm,
  input  wire logic [15:0]            next_offset,
  input  wire logic [15:0]            start_offset,
  input  wire logic [2:0]             length,
  output x86dec_pkg::out_item_t       item
);
  import x86dec_pkg::*;

  kind_t      kind;
  logic [1:0] dl;
  logic [1:0] il;

  assign kind = classify(opcode);
  assign dl   = disp_len(kind, modrm);
  assign il   = imm_len(kind, opcode);

  always_comb begin
    item              = '0;
    item.start_offset = start_offset;
    item.length       = length;

    case (kind)
      K_RMREG:          item.form = FORM_RM_REG;
      K_IMMREG:         item.form = FORM_IMM_REG;
      K_IMMRM, K_GROUP: item.form = FORM_IMM_RM;
      K_MEMACC:         item.form = FORM_MEM_TO_ACC;
      K_ACCMEM:         item.form = FORM_ACC_TO_MEM;
      K_IMMACC:         item.form = FORM_IMM_ACC;
      K_REL:            item.form = FORM_RELATIVE;
      default:          item.form = FORM_RM_REG;
    endcase

    if (kind == K_RMREG || kind == K_IMMACC) begin
      if (opcode[7:3] == TOP_ADD) begin
        item.operation = OP_ADD;
      end else if (opcode[7:3] == TOP_SUB) begin
        item.operation = OP_SUB;
      end else if (opcode[7:3] == TOP_CMP) begin
        item.operation = OP_CMP;
      end else begin
        item.operation = OP_MOV;
      end
    end else if (kind == K_GROUP) begin
      if (modrm[5:3] == GRP_ADD) begin
        item.operation = OP_ADD;
      end else if (modrm[5:3] == GRP_SUB) begin
        item.operation = OP_SUB;
      end else if (modrm[5:3] == GRP_CMP) begin
        item.operation = OP_CMP;
      end else begin
        item.operation = OP_MOV;
        item.invalid   = 1'b1;
      end
    end else if (kind == K_REL) begin
      item.operation = OP_JUMP;
    end

    if (kind == K_IMMREG) begin
      item.wide = opcode[3];
    end else if (kind != K_REL && kind != K_BAD) begin
      item.wide = opcode[0];
    end

    if (kind == K_RMREG) begin
      item.to_register = opcode[1];
    end
    if (kind == K_RMREG || kind == K_IMMRM || kind == K_GROUP) begin
      item.modrm_value = modrm;
    end

    if (dl == 2'd1) begin
      item.displacement = sext8(disp[7:0]);
    end else if (dl == 2'd2) begin
      item.displacement = disp;
    end

    if (il == 2'd2) begin
      item.immediate = imm;
    end else if (il == 2'd1) begin
      item.immediate = (kind == K_GROUP && opcode[1]) ? sext8(imm[7:0]) : {8'h00, imm[7:0]};
    end

    if (kind == K_REL) begin
      item.jump_kind   = (opcode[7:4] == JCC_NIBBLE) ? {1'b0, opcode[3:0]}
                                                     : {3'b100, opcode[1:0]};
      item.jump_target = next_offset + sext8(disp[7:0]);
    end

    if (kind == K_BAD) begin
      item.invalid = 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: tb/x86_16bit_instruction_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder_unit_tb
// Feeds 8086 code bytes through the decoder and checks every decoded
// instruction against a cycle-free decoder written here. A short fixed stream
// comes first, then random instruction streams with truncated instructions,
// restarts and stray bytes, under changing stall patterns and a long output
// hold.
// ----------------------------------------------------------------------------
module x86_16bit_instruction_decoder_unit_tb;
  import x86dec_pkg::*;

  localparam int OFF_W          = OffsetBitsDefault;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 20;

  // opcode prefixes
  localparam logic [5:0] PFX_MOV_RM      = 6'b100010;
  localparam logic [3:0] PFX_MOV_IMM_REG = 4'b1011;
  localparam logic [6:0] PFX_MOV_IMM_RM  = 7'b1100011;
  localparam logic [5:0] PFX_MOV_ACC     = 6'b101000;
  localparam logic [5:0] PFX_IMM_GROUP   = 6'b100000;
  localparam logic [5:0] PFX_LOOP        = 6'b111000;
  localparam logic       ALU_RM          = 1'b0;
  localparam logic [1:0] ALU_IMM_ACC     = 2'b10;

  typedef enum logic [2:0] {
    ST_OPCODE, ST_MODRM, ST_DISP_LO, ST_DISP_HI, ST_IMM_LO, ST_IMM_HI, ST_REL, ST_DONE
  } step_t;

  typedef struct packed {
    logic [7:0] code;
    logic       restart;
  } code_txn_t;

  logic clk;
  logic rst_n;

  x86dec_in_if  in_ch();
  x86dec_out_if out_ch();

  x86_16bit_instruction_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  code_txn_t  byte_backlog[$];
  out_item_t  expected_insns[$];
  int         queued = 0;
  int         bytes_accepted = 0;
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_at = 32'h7fffffff;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  int         quiet_cycles = 0;

  // decoder state
  step_t            dec_step = ST_OPCODE;
  logic [7:0]       dec_opcode = '0;
  logic [7:0]       dec_modrm = '0;
  logic [15:0]      dec_disp = '0;
  logic [15:0]      dec_imm = '0;
  logic [OFF_W-1:0] dec_offset = '0;
  logic [OFF_W-1:0] dec_start = '0;

  function automatic kind_t opcode_kind(input logic [7:0] o);
    if (o[7:2] == PFX_MOV_RM) return K_RMREG;
    if (o[7:4] == PFX_MOV_IMM_REG) return K_IMMREG;
    if (o[7:1] == PFX_MOV_IMM_RM) return K_IMMRM;
    if (o[7:2] == PFX_MOV_ACC) return o[1] ? K_ACCMEM : K_MEMACC;
    if (o[7:2] == PFX_IMM_GROUP) return K_GROUP;
    if (o[7:4] == JCC_NIBBLE || o[7:2] == PFX_LOOP) return K_REL;
    if (o[7:3] == TOP_ADD || o[7:3] == TOP_SUB || o[7:3] == TOP_CMP) begin
      if (o[2] == ALU_RM) return K_RMREG;
      if (o[2:1] == ALU_IMM_ACC) return K_IMMACC;
    end
    return K_BAD;
  endfunction

  function automatic int disp_bytes(input kind_t k, input logic [7:0] m);
    case (k)
      K_MEMACC, K_ACCMEM: return 2;
      K_RMREG, K_IMMRM, K_GROUP: begin
        case (m[7:6])
          MOD_DISP8:  return 1;
          MOD_DISP16: return 2;
          MOD_MEM:    return (m[2:0] == RM_DIRECT) ? 2 : 0;
          default:    return 0;
        endcase
      end
      default: return 0;
    endcase
  endfunction

  function automatic int imm_bytes(input kind_t k, input logic [7:0] o);
    case (k)
      K_IMMREG:          return o[3] ? 2 : 1;
      K_IMMRM, K_IMMACC: return o[0] ? 2 : 1;
      K_GROUP:           return (o[1:0] == 2'b01) ? 2 : 1;
      default:           return 0;
    endcase
  endfunction

  function automatic bit step_used(input step_t s, input kind_t k, input logic [7:0] o,
                                   input logic [7:0] m);
    case (s)
      ST_MODRM:   return k == K_RMREG || k == K_IMMRM || k == K_GROUP;
      ST_DISP_LO: return disp_bytes(k, m) >= 1;
      ST_DISP_HI: return disp_bytes(k, m) == 2;
      ST_IMM_LO:  return imm_bytes(k, o) >= 1;
      ST_IMM_HI:  return imm_bytes(k, o) == 2;
      ST_REL:     return k == K_REL;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic step_t step_after(input step_t s, input kind_t k, input logic [7:0] o,
                                       input logic [7:0] m);
    step_t p;
    p = step_t'(s + 1);
    while (p != ST_DONE && !step_used(p, k, o, m)) p = step_t'(p + 1);
    return p;
  endfunction

  function automatic out_item_t describe_instruction(input kind_t k, input logic [2:0] len);
    out_item_t r;
    int db, ib;
    r  = '0;
    db = disp_bytes(k, dec_modrm);
    ib = imm_bytes(k, dec_opcode);
    case (k)
      K_IMMREG:         r.form = FORM_IMM_REG;
      K_IMMRM, K_GROUP: r.form = FORM_IMM_RM;
      K_MEMACC:         r.form = FORM_MEM_TO_ACC;
      K_ACCMEM:         r.form = FORM_ACC_TO_MEM;
      K_IMMACC:         r.form = FORM_IMM_ACC;
      K_REL:            r.form = FORM_RELATIVE;
      default:          r.form = FORM_RM_REG;
    endcase
    if (k == K_RMREG || k == K_IMMACC) begin
      case (dec_opcode[7:3])
        TOP_ADD: r.operation = OP_ADD;
        TOP_SUB: r.operation = OP_SUB;
        TOP_CMP: r.operation = OP_CMP;
        default: r.operation = OP_MOV;
      endcase
    end else if (k == K_GROUP) begin
      case (dec_modrm[5:3])
        GRP_ADD: r.operation = OP_ADD;
        GRP_SUB: r.operation = OP_SUB;
        GRP_CMP: r.operation = OP_CMP;
        default: r.invalid = 1'b1;
      endcase
    end else if (k == K_REL) begin
      r.operation = OP_JUMP;
    end
    if (k == K_IMMREG) r.wide = dec_opcode[3];
    else if (k != K_REL && k != K_BAD) r.wide = dec_opcode[0];
    if (k == K_RMREG) r.to_register = dec_opcode[1];
    if (k == K_RMREG || k == K_IMMRM || k == K_GROUP) r.modrm_value = dec_modrm;
    if (db == 1) r.displacement = {{8{dec_disp[7]}}, dec_disp[7:0]};
    else if (db == 2) r.displacement = dec_disp;
    if (ib == 2) r.immediate = dec_imm;
    else if (ib == 1 && k == K_GROUP && dec_opcode[1])
      r.immediate = {{8{dec_imm[7]}}, dec_imm[7:0]};
    else if (ib == 1) r.immediate = {8'h00, dec_imm[7:0]};
    if (k == K_REL) begin
      r.jump_kind   = (dec_opcode[7:4] == JCC_NIBBLE) ? {1'b0, dec_opcode[3:0]}
                                                      : {3'b100, dec_opcode[1:0]};
      r.jump_target = dec_start[15:0] + 16'(len) + {{8{dec_disp[7]}}, dec_disp[7:0]};
    end
    if (k == K_BAD) r.invalid = 1'b1;
    r.start_offset = dec_start[15:0];
    r.length       = len;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic restart, output bit produced,
                             output out_item_t res);
    kind_t k;
    step_t nxt;
    if (restart) begin
      dec_step   = ST_OPCODE;
      dec_offset = '0;
    end
    case (dec_step)
      ST_OPCODE: begin
        dec_start  = dec_offset;
        dec_opcode = b;
        dec_modrm  = '0;
        dec_disp   = '0;
        dec_imm    = '0;
      end
      ST_MODRM:           dec_modrm = b;
      ST_DISP_LO, ST_REL: dec_disp = {8'h00, b};
      ST_DISP_HI:         dec_disp[15:8] = b;
      ST_IMM_LO:          dec_imm = {8'h00, b};
      ST_IMM_HI:          dec_imm[15:8] = b;
      default: ;
    endcase
    dec_offset = dec_offset + OFF_W'(1);
    k   = opcode_kind(dec_opcode);
    nxt = (k == K_BAD) ? ST_DONE : step_after(dec_step, k, dec_opcode, dec_modrm);
    produced = 1'b0;
    res      = '0;
    if (nxt == ST_DONE) begin
      produced = 1'b1;
      res      = describe_instruction(k, 3'(dec_offset - dec_start));
      dec_step = ST_OPCODE;
    end else begin
      dec_step = nxt;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (error_count < PRINT_LIMIT)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic push_code(input logic [7:0] b, input logic r);
    code_txn_t t;
    t.code       = b;
    t.restart    = r;
    byte_backlog = {byte_backlog, t};
    queued++;
  endtask

  // one instruction with random content, cut after keep bytes
  task automatic queue_instruction(input logic restart, input int keep);
    logic [7:0] body[$];
    logic [7:0] o, m;
    logic [4:0] top;
    kind_t      k;
    int         extra;
    case ($urandom_range(2))
      0:       top = TOP_ADD;
      1:       top = TOP_SUB;
      default: top = TOP_CMP;
    endcase
    case ($urandom_range(8))
      0:       o = {PFX_MOV_RM, 2'($urandom_range(3))};
      1:       o = {top, ALU_RM, 2'($urandom_range(3))};
      2:       o = {PFX_MOV_IMM_REG, 4'($urandom_range(15))};
      3:       o = {PFX_MOV_IMM_RM, 1'($urandom_range(1))};
      4:       o = {PFX_MOV_ACC, 2'($urandom_range(3))};
      5, 6:    o = {PFX_IMM_GROUP, 2'($urandom_range(3))};
      7:       o = {top, ALU_IMM_ACC, 1'($urandom_range(1))};
      default: o = $urandom_range(1) ? {JCC_NIBBLE, 4'($urandom_range(15))}
                                     : {PFX_LOOP, 2'($urandom_range(3))};
    endcase
    k = opcode_kind(o);
    m = 8'($urandom);
    if (k == K_GROUP && $urandom_range(3) != 0) begin
      case ($urandom_range(2))
        0:       m[5:3] = GRP_ADD;
        1:       m[5:3] = GRP_SUB;
        default: m[5:3] = GRP_CMP;
      endcase
    end
    if ($urandom_range(7) == 0) begin
      m[7:6] = MOD_MEM;
      m[2:0] = RM_DIRECT;
    end
    body = {body, o};
    if (step_used(ST_MODRM, k, o, m)) body = {body, m};
    extra = disp_bytes(k, m) + imm_bytes(k, o) + ((k == K_REL) ? 1 : 0);
    repeat (extra) body = {body, 8'($urandom)};
    foreach (body[i]) begin
      if (i < keep) push_code(body[i], restart && i == 0);
    end
  endtask

  task automatic queue_random(input int count);
    int stop_at;
    int pick;
    stop_at = queued + count;
    while (queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        push_code(8'($urandom), $urandom_range(7) == 0);
      end else if (pick < 14) begin
        queue_instruction(1'b0, 1 + $urandom_range(3));
        queue_instruction(1'b1, 7);
      end else begin
        queue_instruction($urandom_range(39) == 0, 7);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // byte driver
  always @(posedge clk) begin : drive_bytes
    code_txn_t nxt;
    bit        produced;
    out_item_t want;
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.code_byte     <= '0;
      in_ch.program_start <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.code_byte, in_ch.program_start, produced, want);
        if (produced) expected_insns = {expected_insns, want};
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_backlog.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.code_byte     <= nxt.code;
          in_ch.program_start <= nxt.restart;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : collect_results
    out_item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_insns.size() == 0) begin
          report_mismatch("unexpected transaction", out_ch.start_offset, '0);
        end else begin
          want = expected_insns.pop_front();
          if (out_ch.operation !== want.operation)
            report_mismatch("operation", 16'(out_ch.operation), 16'(want.operation));
          if (out_ch.form !== want.form)
            report_mismatch("form", 16'(out_ch.form), 16'(want.form));
          if (out_ch.jump_kind !== want.jump_kind)
            report_mismatch("jump_kind", 16'(out_ch.jump_kind), 16'(want.jump_kind));
          if (out_ch.wide !== want.wide)
            report_mismatch("wide", 16'(out_ch.wide), 16'(want.wide));
          if (out_ch.to_register !== want.to_register)
            report_mismatch("to_register", 16'(out_ch.to_register), 16'(want.to_register));
          if (out_ch.modrm_value !== want.modrm_value)
            report_mismatch("modrm_value", 16'(out_ch.modrm_value), 16'(want.modrm_value));
          if (out_ch.displacement !== want.displacement)
            report_mismatch("displacement", out_ch.displacement, want.displacement);
          if (out_ch.immediate !== want.immediate)
            report_mismatch("immediate", out_ch.immediate, want.immediate);
          if (out_ch.jump_target !== want.jump_target)
            report_mismatch("jump_target", out_ch.jump_target, want.jump_target);
          if (out_ch.start_offset !== want.start_offset)
            report_mismatch("start_offset", out_ch.start_offset, want.start_offset);
          if (out_ch.length !== want.length)
            report_mismatch("length", 16'(out_ch.length), 16'(want.length));
          if (out_ch.invalid !== want.invalid)
            report_mismatch("invalid", 16'(out_ch.invalid), 16'(want.invalid));
        end
      end
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && bytes_accepted >= hold_at) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] opening[$];
    rst_n         = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 46;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // mov with negative disp8, cmp group with sign-extended imm8, bad group reg,
    // unknown opcode, direct address with imm16, jcc wrapping below zero,
    // jcxz, acc-to-mem, then a partial add dropped by a restart
    opening = '{8'h8B, 8'h46, 8'hFE, 8'h83, 8'h7E, 8'h80, 8'hFF, 8'h80, 8'hD0, 8'h05,
                8'hFF, 8'hC7, 8'h06, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h74, 8'h80, 8'hE3,
                8'h7F, 8'hA2, 8'h00, 8'h80};
    foreach (opening[i]) push_code(opening[i], 1'b0);
    push_code(8'h05, 1'b0);
    push_code(8'hB0, 1'b1);
    push_code(8'hFF, 1'b0);
    queue_random(508);
    while (byte_backlog.size() != 0) @(negedge clk);

    send_idle_pct = 46;
    recv_idle_pct = 7;
    queue_random(508);
    while (byte_backlog.size() != 0) @(negedge clk);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_at       = bytes_accepted + 20;
    queue_random(508);

    while (byte_backlog.size() != 0 || in_ch.valid) @(negedge clk);
    while (expected_insns.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
